// ----- sv/byte_ring_fifo_with_delimited_read_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_DELIMITED_READ_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_DELIMITED_READ_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// Types and fixed widths shared by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int ACT_W  = 2;
  localparam int BYTE_W = 8;
  localparam int RUN_W  = 7;
  localparam int SIZE_W = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_COUNT = 2'd1,
    ACT_DELIM = 2'd2,
    ACT_NONE  = 2'd3
  } brf_act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_NIL,
    ST_FETCH,
    ST_POP,
    ST_EMIT
  } brf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;    // capture the input item
    logic fetch;    // read the store at the read index
    logic pop;      // take the fetched byte, advance, prefetch the next one
    logic wr_emit;  // commit a write and load its result
    logic nil_emit; // load an empty-read result
    logic rd_emit;  // load a byte result
  } brf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    brf_act_t act;
    logic     empty;
    logic     cnt_zero;
    logic     more;
    logic     at_cap;
    logic     out_free;
  } brf_stat_t;

endpackage

// ----- sv/byte_ring_fifo_with_delimited_read_unit.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_delimited_read_unit
// Byte ring FIFO with write, counted read and read-until-delimiter items.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Moves
//   in_      input      in_valid / in_ready   one item: write, counted or
//                                             delimited read
//   out_     output     out_valid / out_ready one result per transfer, one or
//                                             more per item, none for ACT_NONE
//   cfg_     input      cfg_wr_en             size_in_use, no wait
//
// Steps: a write or an empty read goes from transfer to result through
// accept, decode and result load; a read run reaches its first byte
// through accept, decode, fetch, pop and result load, and each further
// byte through pop and prefetch, then compare and result load, as set by
// the single registered read port of the byte store.
// One item is in flight at a time; in_ready is high only while idle.
// A stalled out_ready holds the sequencer in place; nothing is dropped.
// Reset (rst_n low, synchronous) empties the FIFO and sets min(DEPTH, 256)
// slots in use; the byte store is not cleared, so no clearing pass runs.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_delimited_read_unit #(
  parameter int DEPTH   = 256,
  parameter int MAX_RUN = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [brf_pkg::ACT_W-1:0]  in_action,
  input  logic [brf_pkg::BYTE_W-1:0] in_write_byte,
  input  logic [brf_pkg::RUN_W-1:0]  in_read_count,
  input  logic [brf_pkg::BYTE_W-1:0] in_delimiter,
  input  logic                       in_last_in_burst,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brf_pkg::BYTE_W-1:0] out_read_byte,
  output logic                       out_valid_res,
  output logic [brf_pkg::RUN_W-1:0]  out_run_index,
  output logic                       out_last,
  output logic                       out_capped,
  output logic                       out_now_full,
  output logic                       out_now_empty,
  // Configuration
  input  logic                       cfg_wr_en,
  input  logic [brf_pkg::SIZE_W-1:0] cfg_size_in_use
);

  // in_last_in_burst is carried on the port for the burst source; every
  // write item stands alone, so the block does not act on it.

  brf_pkg::brf_cmd_t  cmd;
  brf_pkg::brf_stat_t stat;

  // Sequencer: one item at a time, drives commands into the datapath
  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: store, indices, item capture and the result register
  brf_dp #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_write_byte   (in_write_byte),
    .in_read_count   (in_read_count),
    .in_delimiter    (in_delimiter),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_size_in_use (cfg_size_in_use),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_byte   (out_read_byte),
    .out_valid_res   (out_valid_res),
    .out_run_index   (out_run_index),
    .out_last        (out_last),
    .out_capped      (out_capped),
    .out_now_full    (out_now_full),
    .out_now_empty   (out_now_empty)
  );

endmodule

// ----- sv/brf_ctrl.sv -----
// ----------------------------------------------------------------------------
// brf_ctrl
// Sequencer for one item at a time: decode, write, empty read, byte runs.
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  brf_pkg::brf_stat_t stat,
  output brf_pkg::brf_cmd_t  cmd
);

  brf_pkg::brf_state_t state_r;
  brf_pkg::brf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = brf_pkg::ST_DECODE;
      end
      brf_pkg::ST_DECODE: begin
        unique case (stat.act)
          brf_pkg::ACT_WRITE: state_nxt = brf_pkg::ST_WRITE;
          brf_pkg::ACT_NONE:  state_nxt = brf_pkg::ST_IDLE;
          brf_pkg::ACT_COUNT: begin
            state_nxt = (stat.empty || stat.cnt_zero) ? brf_pkg::ST_NIL
                                                      : brf_pkg::ST_FETCH;
          end
          brf_pkg::ACT_DELIM: begin
            state_nxt = stat.empty ? brf_pkg::ST_NIL : brf_pkg::ST_FETCH;
          end
        endcase
      end
      brf_pkg::ST_WRITE, brf_pkg::ST_NIL: begin
        if (stat.out_free) state_nxt = brf_pkg::ST_IDLE;
      end
      brf_pkg::ST_FETCH: state_nxt = brf_pkg::ST_POP;
      brf_pkg::ST_POP:   state_nxt = brf_pkg::ST_EMIT;
      brf_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = (stat.more && !stat.at_cap) ? brf_pkg::ST_POP : brf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brf_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      brf_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      brf_pkg::ST_DECODE: ;
      brf_pkg::ST_WRITE:  cmd.wr_emit  = stat.out_free;
      brf_pkg::ST_NIL:    cmd.nil_emit = stat.out_free;
      brf_pkg::ST_FETCH:  cmd.fetch    = 1'b1;
      brf_pkg::ST_POP:    cmd.pop      = 1'b1;
      brf_pkg::ST_EMIT:   cmd.rd_emit  = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- sv/brf_dp.sv -----
// ----------------------------------------------------------------------------
// brf_dp
// Byte store, ring indices, item registers and the result register.
// ----------------------------------------------------------------------------
module brf_dp #(
  parameter int DEPTH   = 256,
  parameter int MAX_RUN = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  brf_pkg::brf_cmd_t            cmd,
  output brf_pkg::brf_stat_t           stat,
  input  logic [brf_pkg::ACT_W-1:0]    in_action,
  input  logic [brf_pkg::BYTE_W-1:0]   in_write_byte,
  input  logic [brf_pkg::RUN_W-1:0]    in_read_count,
  input  logic [brf_pkg::BYTE_W-1:0]   in_delimiter,
  input  logic                         cfg_wr_en,
  input  logic [brf_pkg::SIZE_W-1:0]   cfg_size_in_use,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [brf_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                         out_valid_res,
  output logic [brf_pkg::RUN_W-1:0]    out_run_index,
  output logic                         out_last,
  output logic                         out_capped,
  output logic                         out_now_full,
  output logic                         out_now_empty
);

  localparam int AW      = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int SW      = (AW + 1 > brf_pkg::SIZE_W) ? AW + 1 : brf_pkg::SIZE_W;
  localparam int RstSize = (DEPTH < 256) ? DEPTH : 256;
  localparam logic [AW-1:0]             RstLast = AW'(RstSize - 1);
  localparam logic [brf_pkg::RUN_W-1:0] MaxRun  = brf_pkg::RUN_W'(MAX_RUN);

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx,
                                        input logic [AW-1:0] last_slot);
    adv = (idx == last_slot) ? '0 : idx + AW'(1);
  endfunction

  logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];

  logic [AW-1:0]              wr_idx_r;
  logic [AW-1:0]              rd_idx_r;
  logic [AW-1:0]              last_slot_r;
  brf_pkg::brf_act_t          act_r;
  logic [brf_pkg::BYTE_W-1:0] wbyte_r;
  logic [brf_pkg::RUN_W-1:0]  count_r;
  logic [brf_pkg::BYTE_W-1:0] delim_r;
  logic [brf_pkg::RUN_W-1:0]  got_r;
  logic [brf_pkg::BYTE_W-1:0] rdata_r;
  logic [brf_pkg::BYTE_W-1:0] byte_r;
  logic                       out_valid_r;

  logic [SW-1:0]  size_ext;
  logic [SW-1:0]  size_cl;
  logic [AW-1:0]  last_slot_nxt;
  logic [AW-1:0]  wr_adv;
  logic [AW-1:0]  rd_adv;
  logic [AW-1:0]  rd_addr;
  logic           empty;
  logic           full;
  logic           full_after_wr;
  logic           empty_after_wr;
  logic           more;
  logic           at_cap;
  logic           out_free;

  // Clamp the slot count into 2..DEPTH and keep the wrap point
  always_comb begin
    size_ext = SW'(cfg_size_in_use);
    if (size_ext < SW'(2)) begin
      size_cl = SW'(2);
    end else if (size_ext > SW'(DEPTH)) begin
      size_cl = SW'(DEPTH);
    end else begin
      size_cl = size_ext;
    end
    last_slot_nxt = AW'(size_cl - SW'(1));
  end

  always_comb begin
    wr_adv         = adv(wr_idx_r, last_slot_r);
    rd_adv         = adv(rd_idx_r, last_slot_r);
    empty          = (wr_idx_r == rd_idx_r);
    full           = (wr_adv == rd_idx_r);
    full_after_wr  = full ? 1'b1 : (adv(wr_adv, last_slot_r) == rd_idx_r);
    empty_after_wr = full ? empty : 1'b0;
    rd_addr        = cmd.pop ? rd_adv : rd_idx_r;
    at_cap         = (got_r >= MaxRun);
    if (act_r == brf_pkg::ACT_COUNT) begin
      more = (got_r < count_r) && !empty;
    end else begin
      // rdata_r holds the byte now at the read index (prefetched on pop)
      more = !empty && (rdata_r != delim_r);
    end
    out_free = !out_valid_r || out_ready;
  end

  assign stat.act      = act_r;
  assign stat.empty    = empty;
  assign stat.cnt_zero = (count_r == '0);
  assign stat.more     = more;
  assign stat.at_cap   = at_cap;
  assign stat.out_free = out_free;

  // Store write port
  always_ff @(posedge clk) begin
    if (cmd.wr_emit && !full) begin
      mem[wr_idx_r] <= wbyte_r;
    end
  end

  // Store read port, registered
  always_ff @(posedge clk) begin
    if (cmd.fetch || cmd.pop) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Ring indices and wrap point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      last_slot_r <= RstLast;
    end else if (cfg_wr_en) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      last_slot_r <= last_slot_nxt;
    end else begin
      if (cmd.wr_emit && !full) wr_idx_r <= wr_adv;
      if (cmd.pop)              rd_idx_r <= rd_adv;
    end
  end

  // Item registers and run counter
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= brf_pkg::brf_act_t'(in_action);
      wbyte_r <= in_write_byte;
      count_r <= in_read_count;
      delim_r <= in_delimiter;
      got_r   <= '0;
    end else if (cmd.pop) begin
      got_r   <= got_r + brf_pkg::RUN_W'(1);
    end
    if (cmd.pop) begin
      byte_r <= rdata_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wr_emit || cmd.nil_emit || cmd.rd_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_emit) begin
      out_read_byte <= '0;
      out_valid_res <= !full;
      out_run_index <= '0;
      out_last      <= 1'b1;
      out_capped    <= 1'b0;
      out_now_full  <= full_after_wr;
      out_now_empty <= empty_after_wr;
    end else if (cmd.nil_emit) begin
      out_read_byte <= '0;
      out_valid_res <= 1'b0;
      out_run_index <= '0;
      out_last      <= 1'b1;
      out_capped    <= 1'b0;
      out_now_full  <= full;
      out_now_empty <= empty;
    end else if (cmd.rd_emit) begin
      out_read_byte <= byte_r;
      out_valid_res <= 1'b1;
      out_run_index <= got_r;
      out_last      <= !more || at_cap;
      out_capped    <= more && at_cap;
      out_now_full  <= full;
      out_now_empty <= empty;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/brf_chk.sv -----
// ----------------------------------------------------------------------------
// brf_chk
// Port-level checker for the byte ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_with_delimited_read_unit_assert.svh"

module brf_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brf_pkg::BYTE_W-1:0] out_read_byte,
  input logic                       out_valid_res,
  input logic [brf_pkg::RUN_W-1:0]  out_run_index,
  input logic                       out_last,
  input logic                       out_capped,
  input logic                       out_now_full,
  input logic                       out_now_empty
);

  // A stalled result holds until its transfer
  `BRF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_byte) && $stable(out_run_index) && $stable(out_last) && $stable(out_valid_res), "result changed while stalled")

  // Full and empty never show together
  `BRF_ASSERT_IMP(a_full_empty, out_valid, !(out_now_full && out_now_empty), "full and empty both set")

  // A capped run ends the item on a delivered byte
  `BRF_ASSERT_IMP(a_capped_end, out_valid && out_capped, out_last && out_valid_res && (out_run_index != '0), "capped flag on a non-final or empty result")

  // A refused write or empty read is a lone zero result
  `BRF_ASSERT_IMP(a_nil_shape, out_valid && !out_valid_res, out_last && !out_capped && (out_read_byte == '0) && (out_run_index == '0), "bad shape on a result without data")

endmodule

bind byte_ring_fifo_with_delimited_read_unit brf_chk u_brf_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_byte (out_read_byte),
  .out_valid_res (out_valid_res),
  .out_run_index (out_run_index),
  .out_last      (out_last),
  .out_capped    (out_capped),
  .out_now_full  (out_now_full),
  .out_now_empty (out_now_empty)
);
